// ===== design/mpqs_pkg.sv =====
package mpqs_pkg;

  // Storage geometry.
  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Field widths of one transaction.
  localparam int OP_W        = 2;
  localparam int DATA_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int ENTRY_W     = 2 * DATA_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

// ===== design/mpqs_ram.sv =====
module mpqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/max_priority_queue_scan.sv =====
// Enqueue, full, empty and unknown operations: result strobe raised at the edge after the accepting edge.
// Peek: the strobe follows a scan that reads one entry per cycle through the single RAM read
// port and one comparator, and then the finish state.
// Remove: the same scan and finish state, then a shift state that compacts the entries behind the
// maximum. busy falls with the strobe, so the next transaction can be taken while the strobe is
// high; the receiver cannot stall. Synchronous reset empties the store (count zero).
module max_priority_queue_scan import mpqs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        operation,
  input  logic [DATA_W-1:0]      process_id,
  input  logic [DATA_W-1:0]      wait_time,
  output logic                   done,
  output logic [STATUS_W-1:0]    status,
  output logic [DATA_W-1:0]      found_id,
  output logic [DATA_W-1:0]      found_time,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN,
    S_SHIFT
  } state_t;

  state_t              state;
  logic [OP_W-1:0]     op_q;
  logic [DATA_W-1:0]   pid_q;
  logic [DATA_W-1:0]   wt_q;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  ptr;
  logic                rd_valid;
  logic [ADDR_W-1:0]   rd_idx;
  logic                first;
  logic [ADDR_W-1:0]   best_idx;
  logic [DATA_W-1:0]   best_id;
  logic [DATA_W-1:0]   best_time;

  logic                issue;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [DATA_W-1:0]   rd_id;
  logic [DATA_W-1:0]   rd_time;

  assign busy    = (state != S_IDLE);
  assign rd_id   = ram_rdata[ENTRY_W-1:DATA_W];
  assign rd_time = ram_rdata[DATA_W-1:0];

  // A read is issued each cycle of a scan or shift until the pointer reaches the count.
  assign issue = ((state == S_SCAN) || (state == S_SHIFT)) && (ptr != count);

  // Write port: append on enqueue, or move an entry down by one slot during compaction.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[ADDR_W-1:0];
    ram_wdata = {pid_q, wt_q};
    if ((state == S_EXEC) && (op_q == OP_ENQUEUE) && (count != COUNT_W'(QUEUE_DEPTH))) begin
      ram_we = 1'b1;
    end else if ((state == S_SHIFT) && rd_valid) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx - ADDR_W'(1);
      ram_wdata = ram_rdata;
    end
  end

  mpqs_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // Sequencer with the registered result. The strobe is only ever raised on the way back
  // to idle, so the idle state is where it drops again.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      rd_idx   <= ptr[ADDR_W-1:0];
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            op_q  <= operation;
            pid_q <= process_id;
            wt_q  <= wait_time;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q) inside
            OP_ENQUEUE: begin
              done       <= 1'b1;
              found_id   <= '0;
              found_time <= '0;
              state      <= S_IDLE;
              if (count == COUNT_W'(QUEUE_DEPTH)) begin
                status      <= STATUS_FULL;
                entry_count <= COUNT_OUT_W'(count);
              end else begin
                status      <= STATUS_OK;
                count       <= count + COUNT_W'(1);
                entry_count <= COUNT_OUT_W'(count + COUNT_W'(1));
              end
            end
            OP_REMOVE, OP_PEEK: begin
              if (count == '0) begin
                done        <= 1'b1;
                status      <= STATUS_EMPTY;
                found_id    <= '0;
                found_time  <= '0;
                entry_count <= COUNT_OUT_W'(count);
                state       <= S_IDLE;
              end else begin
                ptr   <= '0;
                first <= 1'b1;
                state <= S_SCAN;
              end
            end
            default: begin
              done        <= 1'b1;
              status      <= STATUS_OK;
              found_id    <= '0;
              found_time  <= '0;
              entry_count <= COUNT_OUT_W'(count);
              state       <= S_IDLE;
            end
          endcase
        end
        S_SCAN: begin
          if (issue) begin
            ptr <= ptr + COUNT_W'(1);
          end
          // Strictly greater keeps the earliest entry on ties.
          if (rd_valid) begin
            if (first || (rd_time > best_time)) begin
              best_id   <= rd_id;
              best_time <= rd_time;
              best_idx  <= rd_idx;
            end
            first <= 1'b0;
            if (!issue) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (op_q == OP_PEEK) begin
            done        <= 1'b1;
            status      <= STATUS_OK;
            found_id    <= best_id;
            found_time  <= best_time;
            entry_count <= COUNT_OUT_W'(count);
            state       <= S_IDLE;
          end else begin
            ptr   <= COUNT_W'(best_idx) + COUNT_W'(1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (issue) begin
            ptr <= ptr + COUNT_W'(1);
          end
          // Finished once every entry behind the maximum has moved down.
          if (!issue && !rd_valid) begin
            count       <= count - COUNT_W'(1);
            done        <= 1'b1;
            status      <= STATUS_OK;
            found_id    <= best_id;
            found_time  <= best_time;
            entry_count <= COUNT_OUT_W'(count - COUNT_W'(1));
            state       <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/mpqs_checker.sv =====
`timescale 1ns / 1ps

// Watches both sides of the queue, keeps a shadow copy of the stored entries and
// checks every result transaction against the reply predicted for its request.
module mpqs_checker import mpqs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic [OP_W-1:0]        operation,
  input  logic [DATA_W-1:0]      process_id,
  input  logic [DATA_W-1:0]      wait_time,
  input  logic                   done,
  input  logic [STATUS_W-1:0]    status,
  input  logic [DATA_W-1:0]      found_id,
  input  logic [DATA_W-1:0]      found_time,
  input  logic [COUNT_OUT_W-1:0] entry_count,
  output int                     pending,
  output int                     error_count
);

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [DATA_W-1:0]      found_id;
    logic [DATA_W-1:0]      found_time;
    logic [COUNT_OUT_W-1:0] entry_count;
  } reply_t;

  // Shadow of the store, slot 0 the oldest arrival.
  logic [DATA_W-1:0] shadow_ids   [QUEUE_DEPTH];
  logic [DATA_W-1:0] shadow_times [QUEUE_DEPTH];
  int                shadow_count;

  reply_t awaited_replies [$];

  initial begin
    pending     = 0;
    error_count = 0;
  end

  // Applies one request to the shadow store and returns the reply it should give.
  function automatic reply_t serve_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] pid,
                                           logic [DATA_W-1:0] wt);
    reply_t reply;
    int     best;
    reply = '0;
    reply.status = STATUS_OK;
    case (op) inside
      OP_ENQUEUE: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          reply.status = STATUS_FULL;
        end else begin
          shadow_ids[shadow_count]   = pid;
          shadow_times[shadow_count] = wt;
          shadow_count++;
        end
      end
      OP_REMOVE, OP_PEEK: begin
        if (shadow_count == 0) begin
          reply.status = STATUS_EMPTY;
        end else begin
          // Strictly greater, so the earliest arrival wins a tie.
          best = 0;
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_times[i] > shadow_times[best]) best = i;
          end
          reply.found_id   = shadow_ids[best];
          reply.found_time = shadow_times[best];
          // Removal closes the gap and keeps the order of the rest.
          if (op == OP_REMOVE) begin
            for (int i = best; i + 1 < shadow_count; i++) begin
              shadow_ids[i]   = shadow_ids[i + 1];
              shadow_times[i] = shadow_times[i + 1];
            end
            shadow_count--;
          end
        end
      end
      default: begin
      end
    endcase
    reply.entry_count = COUNT_OUT_W'(shadow_count);
    return reply;
  endfunction

  // Result transactions are compared first, then a new request is taken in.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      awaited_replies.delete();
      shadow_count = 0;
    end else begin
      if (done) begin
        if (awaited_replies.size() == 0) begin
          $error("result with no request outstanding: status %0d id %0h time %0h count %0d",
                 status, found_id, found_time, entry_count);
          error_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            error_count++;
          end
          if (found_id !== want.found_id) begin
            $error("found_id: expected %0h, actual %0h", want.found_id, found_id);
            error_count++;
          end
          if (found_time !== want.found_time) begin
            $error("found_time: expected %0h, actual %0h", want.found_time, found_time);
            error_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        awaited_replies.push_back(serve_request(operation, process_id, wait_time));
      end
    end
    pending <= awaited_replies.size();
  end

endmodule

// ===== bench/tb_max_priority_queue_scan.sv =====
`timescale 1ns / 1ps

module tb_max_priority_queue_scan;
  import mpqs_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 440;
  localparam int RUN_LENGTH   = 40;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [OP_W-1:0]        operation = OP_ENQUEUE;
  logic [DATA_W-1:0]      process_id = '0;
  logic [DATA_W-1:0]      wait_time = '0;
  logic                   busy;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [DATA_W-1:0]      found_id;
  logic [DATA_W-1:0]      found_time;
  logic [COUNT_OUT_W-1:0] entry_count;
  int                     pending;
  int                     error_count;
  int                     cycle_count = 0;
  int                     idle_pct = 0;

  always #5 clk = ~clk;

  max_priority_queue_scan uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .process_id(process_id), .wait_time(wait_time),
    .done(done), .status(status), .found_id(found_id), .found_time(found_time),
    .entry_count(entry_count)
  );

  mpqs_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .process_id(process_id), .wait_time(wait_time),
    .done(done), .status(status), .found_id(found_id), .found_time(found_time),
    .entry_count(entry_count), .pending(pending), .error_count(error_count)
  );

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Presents one request and holds it until the edge at which it is taken.
  // Start stays high afterwards so that back-to-back requests need no gap.
  task automatic issue(logic [OP_W-1:0] op, logic [DATA_W-1:0] pid, logic [DATA_W-1:0] wt);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    operation  <= op;
    process_id <= pid;
    wait_time  <= wt;
    do @(posedge clk); while (busy);
  endtask

  // Wait times lean towards a narrow range so that ties are common.
  function automatic logic [DATA_W-1:0] pick_time();
    int roll;
    roll = $urandom_range(9);
    if (roll < 3) return DATA_W'($urandom_range(3));
    if (roll == 3) return $urandom_range(1) ? '1 : '0;
    return DATA_W'($urandom);
  endfunction

  // Enqueue-heavy and remove-heavy runs alternate, so the store swings
  // between empty and full with random content in between.
  task automatic random_phase(int pct);
    int               fill_pct;
    int               roll;
    logic [OP_W-1:0]  op;
    idle_pct = pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % RUN_LENGTH == 0) fill_pct = ((n / RUN_LENGTH) % 2 == 0) ? 75 : 30;
      roll = $urandom_range(99);
      if (roll < 3) op = OP_UNUSED;
      else if ($urandom_range(99) < fill_pct) op = OP_ENQUEUE;
      else op = $urandom_range(2) == 0 ? OP_PEEK : OP_REMOVE;
      issue(op, DATA_W'($urandom), pick_time());
    end
  endtask

  initial begin
    logic [DATA_W-1:0] pid;
    logic [DATA_W-1:0] wt;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store, then a full one with maxima at head, tail and middle.
    issue(OP_REMOVE, 16'h1234, 16'h5678);
    issue(OP_PEEK, '1, '1);
    issue(OP_UNUSED, '1, '1);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      pid = (i == 1) ? '1 : DATA_W'(i * 4099);
      if (i == 0 || i == QUEUE_DEPTH - 1) wt = '1;
      else if (i == 7) wt = 16'hFFFE;
      else if (i == 3 || i == 10) wt = 16'h8000;
      else wt = DATA_W'(i - 1);
      issue(OP_ENQUEUE, pid, wt);
    end
    issue(OP_ENQUEUE, '1, '1);
    issue(OP_UNUSED, '0, '0);
    issue(OP_PEEK, '0, '0);
    repeat (4) issue(OP_REMOVE, '0, '0);

    // Random traffic under several sender idling patterns.
    random_phase(0);
    random_phase(57);
    random_phase(11);
    random_phase(0);
    start <= 1'b0;

    // Let every outstanding result arrive, then a short quiet spell.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
